// ----- hdl/hdrm_pkg.sv -----
// Package for the HID descriptor report matcher.
// Holds the channel payload types, item codes and register indexes.
// No dependencies; every other file imports it.
package hdrm_pkg;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_WANTED_REPORT_ID   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WANTED_FIELD_BITS  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_WANTED_FIELD_COUNT = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [7:0]  WANTED_REPORT_ID_RESET   = 8'd0;
   localparam logic [7:0]  WANTED_FIELD_BITS_RESET  = 8'd8;
   localparam logic [15:0] WANTED_FIELD_COUNT_RESET = 16'd0;

   // Descriptor item codes.
   localparam logic [7:0] LONG_ITEM_PREFIX = 8'hFE;
   localparam logic [1:0] KIND_MAIN        = 2'd0;
   localparam logic [1:0] KIND_GLOBAL      = 2'd1;
   localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
   localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
   localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
   localparam logic [3:0] TAG_FEATURE      = 4'd11;

   // Short item size codes.
   localparam logic [1:0] SIZE_CODE_ZERO = 2'd0;
   localparam logic [1:0] SIZE_CODE_ONE  = 2'd1;
   localparam logic [1:0] SIZE_CODE_TWO  = 2'd2;
   localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

   // Parser phases, one-hot.
   typedef enum logic [4:0] {
      PH_PREFIX    = 5'b00001,
      PH_DATA      = 5'b00010,
      PH_LONG_SIZE = 5'b00100,
      PH_LONG_TAG  = 5'b01000,
      PH_LONG_SKIP = 5'b10000
   } phase_type;

   // Channel payloads.
   typedef struct packed {
      logic [7:0] desc_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic found;
      logic truncated;
   } rsp_payload_type;

   typedef struct packed {
      logic [CsrIndexWidth-1:0] reg_index;
      logic [CsrDataWidth-1:0]  write_data;
   } csr_payload_type;

   // Number of data bytes that follow a short item prefix.
   function automatic logic [2:0] data_byte_count(input logic [1:0] code);
      logic [2:0] size;
      begin
         case (code)
            SIZE_CODE_ZERO: size = 3'd0;
            SIZE_CODE_ONE:  size = 3'd1;
            SIZE_CODE_TWO:  size = 3'd2;
            default:        size = 3'd4;
         endcase
         return size;
      end
   endfunction

endpackage

// ----- hdl/hdrm_if.sv -----
// Valid/ready channel interfaces of the HID descriptor report matcher.
// Depends on hdrm_pkg for the payload types.
interface hdrm_req_if import hdrm_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hdrm_rsp_if import hdrm_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hdrm_csr_if import hdrm_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/hid_descriptor_report_matcher_top.sv -----
// HID report descriptor matcher: parses descriptor bytes and reports a feature match.
// Depends on hdrm_pkg and the channel interfaces in hdrm_if.sv.
//
// Usage:
// The req channel carries one descriptor byte per word, with final_byte set on
// the last byte of a descriptor. The rsp channel gives at most one word per
// descriptor: found=1 at the first Feature item whose Report ID, Report Size
// and Report Count equal the configured values, or found=0 at the last byte,
// with truncated set when the descriptor ends inside a short item or a long
// item header. Bytes after a match are dropped until the last byte.
// The csr channel writes the three wanted values; it is always ready and must
// only be used while no descriptor is in progress.
// A result word is registered, in the skid register if the output is stalled.
// Throughput: one byte per cycle while req ready is high; the parser state is
// updated in the cycle a byte is accepted, so the state registers bound the rate.
// Results pass through an output register and a skid register, so input keeps
// flowing while one result waits; req ready drops only when both are full.
// Reset clears the parser, empties the result registers and restores the
// register defaults (report ID 0, size 8 bits, count 0).
module hid_descriptor_report_matcher_top
   import hdrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   hdrm_req_if.sink    req_chan,
   hdrm_rsp_if.source  rsp_chan,
   hdrm_csr_if.sink    csr_chan
);

   // Configuration registers.
   logic [7:0]  wanted_report_id_ff, wanted_report_id_in;
   logic [7:0]  wanted_field_bits_ff, wanted_field_bits_in;
   logic [15:0] wanted_field_count_ff, wanted_field_count_in;

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [1:0]  item_kind_ff, item_kind_in;
   logic [3:0]  item_label_ff, item_label_in;
   logic [7:0]  skip_count_ff, skip_count_in;
   logic [31:0] value_accum_ff, value_accum_in;
   logic [7:0]  cur_report_id_ff, cur_report_id_in;
   logic        cur_report_id_hi_ff, cur_report_id_hi_in;
   logic [7:0]  cur_field_bits_ff, cur_field_bits_in;
   logic        cur_field_bits_hi_ff, cur_field_bits_hi_in;
   logic [15:0] cur_field_count_ff, cur_field_count_in;
   logic        cur_field_count_hi_ff, cur_field_count_hi_in;
   logic        verdict_ff, verdict_in;

   // Result registers.
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_ff, skid_in;

   logic            accept;
   logic            result_valid;
   rsp_payload_type result;
   logic            csr_write;

   assign accept    = req_chan.valid && req_chan.ready;
   assign csr_write = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready  = !skid_valid_ff;
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   // Register writes.
   always_comb begin
      wanted_report_id_in   = wanted_report_id_ff;
      wanted_field_bits_in  = wanted_field_bits_ff;
      wanted_field_count_in = wanted_field_count_ff;
      if (csr_write) begin
         unique case (csr_chan.payload.reg_index)
            CSR_WANTED_REPORT_ID:
               wanted_report_id_in = csr_chan.payload.write_data[7:0];
            CSR_WANTED_FIELD_BITS:
               wanted_field_bits_in = csr_chan.payload.write_data[7:0];
            CSR_WANTED_FIELD_COUNT:
               wanted_field_count_in = csr_chan.payload.write_data;
            default: begin
            end
         endcase
      end
   end

   // Byte parser: one descriptor byte moves the state on by one step.
   always_comb begin
      logic [7:0]  in_byte;
      logic        in_final;
      logic        finish_go;
      logic [1:0]  fin_kind;
      logic [3:0]  fin_label;
      logic [31:0] fin_value;
      logic [31:0] shifted;
      logic        matched;
      logic        match_hit;

      in_byte   = req_chan.payload.desc_byte;
      in_final  = req_chan.payload.final_byte;
      finish_go = 1'b0;
      fin_kind  = item_kind_ff;
      fin_label = item_label_ff;
      fin_value = value_accum_ff;
      matched   = 1'b0;

      phase_in              = phase_ff;
      bytes_left_in         = bytes_left_ff;
      byte_index_in         = byte_index_ff;
      item_kind_in          = item_kind_ff;
      item_label_in         = item_label_ff;
      skip_count_in         = skip_count_ff;
      value_accum_in        = value_accum_ff;
      cur_report_id_in      = cur_report_id_ff;
      cur_report_id_hi_in   = cur_report_id_hi_ff;
      cur_field_bits_in     = cur_field_bits_ff;
      cur_field_bits_hi_in  = cur_field_bits_hi_ff;
      cur_field_count_in    = cur_field_count_ff;
      cur_field_count_hi_in = cur_field_count_hi_ff;
      verdict_in            = verdict_ff;

      // Data byte placed at its little-endian position.
      shifted = {24'd0, in_byte} << {byte_index_ff, 3'd0};

      // Compare the tracked globals with the wanted values.
      match_hit = !cur_report_id_hi_ff && !cur_field_bits_hi_ff && !cur_field_count_hi_ff
                  && (cur_report_id_ff == wanted_report_id_ff)
                  && (cur_field_bits_ff == wanted_field_bits_ff)
                  && (cur_field_count_ff == wanted_field_count_ff);

      if (accept && !verdict_ff) begin
         unique case (phase_ff)
            PH_DATA: begin
               value_accum_in = value_accum_ff | shifted;
               byte_index_in  = byte_index_ff + 2'd1;
               bytes_left_in  = bytes_left_ff - 3'd1;
               if (bytes_left_ff == 3'd1) begin
                  phase_in  = PH_PREFIX;
                  finish_go = 1'b1;
                  fin_value = value_accum_ff | shifted;
               end
            end
            PH_LONG_SIZE: begin
               skip_count_in = in_byte;
               phase_in      = PH_LONG_TAG;
            end
            PH_LONG_TAG: begin
               phase_in = (skip_count_ff != 8'd0) ? PH_LONG_SKIP : PH_PREFIX;
            end
            PH_LONG_SKIP: begin
               skip_count_in = skip_count_ff - 8'd1;
               if (skip_count_ff == 8'd1) begin
                  phase_in = PH_PREFIX;
               end
            end
            default: begin
               if (in_byte == LONG_ITEM_PREFIX) begin
                  phase_in = PH_LONG_SIZE;
               end else begin
                  item_kind_in   = in_byte[3:2];
                  item_label_in  = in_byte[7:4];
                  value_accum_in = 32'd0;
                  byte_index_in  = 2'd0;
                  if (in_byte[1:0] == SIZE_CODE_ZERO) begin
                     phase_in  = PH_PREFIX;
                     finish_go = 1'b1;
                     fin_kind  = in_byte[3:2];
                     fin_label = in_byte[7:4];
                     fin_value = 32'd0;
                  end else begin
                     bytes_left_in = data_byte_count(in_byte[1:0]);
                     phase_in      = PH_DATA;
                  end
               end
            end
         endcase

         // A completed short item updates a global or checks a feature.
         if (finish_go) begin
            if (fin_kind == KIND_GLOBAL) begin
               if (fin_label == TAG_REPORT_SIZE) begin
                  cur_field_bits_in    = fin_value[7:0];
                  cur_field_bits_hi_in = |fin_value[31:8];
               end else if (fin_label == TAG_REPORT_ID) begin
                  cur_report_id_in    = fin_value[7:0];
                  cur_report_id_hi_in = |fin_value[31:8];
               end else if (fin_label == TAG_REPORT_COUNT) begin
                  cur_field_count_in    = fin_value[15:0];
                  cur_field_count_hi_in = |fin_value[31:16];
               end
            end else if (fin_kind == KIND_MAIN && fin_label == TAG_FEATURE) begin
               matched = match_hit;
            end
         end
      end

      // Result word: a match, or the verdict at the last byte.
      result_valid     = accept && !verdict_ff && (matched || in_final);
      result.found     = matched;
      result.truncated = !matched && (phase_in == PH_DATA || phase_in == PH_LONG_SIZE
                                      || phase_in == PH_LONG_TAG);
      if (matched) begin
         verdict_in = 1'b1;
      end

      // The last byte starts a fresh descriptor.
      if (accept && in_final) begin
         phase_in              = PH_PREFIX;
         bytes_left_in         = 3'd0;
         byte_index_in         = 2'd0;
         item_kind_in          = 2'd0;
         item_label_in         = 4'd0;
         skip_count_in         = 8'd0;
         value_accum_in        = 32'd0;
         cur_report_id_in      = 8'd0;
         cur_report_id_hi_in   = 1'b0;
         cur_field_bits_in     = 8'd0;
         cur_field_bits_hi_in  = 1'b0;
         cur_field_count_in    = 16'd0;
         cur_field_count_hi_in = 1'b0;
         verdict_in            = 1'b0;
      end
   end

   // Output register with a skid register behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = result_valid;
            out_in       = result;
         end
      end else if (result_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_report_id_ff   <= WANTED_REPORT_ID_RESET;
         wanted_field_bits_ff  <= WANTED_FIELD_BITS_RESET;
         wanted_field_count_ff <= WANTED_FIELD_COUNT_RESET;
         phase_ff              <= PH_PREFIX;
         bytes_left_ff         <= 3'd0;
         byte_index_ff         <= 2'd0;
         item_kind_ff          <= 2'd0;
         item_label_ff         <= 4'd0;
         skip_count_ff         <= 8'd0;
         value_accum_ff        <= 32'd0;
         cur_report_id_ff      <= 8'd0;
         cur_report_id_hi_ff   <= 1'b0;
         cur_field_bits_ff     <= 8'd0;
         cur_field_bits_hi_ff  <= 1'b0;
         cur_field_count_ff    <= 16'd0;
         cur_field_count_hi_ff <= 1'b0;
         verdict_ff            <= 1'b0;
         out_valid_ff          <= 1'b0;
         skid_valid_ff         <= 1'b0;
      end else begin
         wanted_report_id_ff   <= wanted_report_id_in;
         wanted_field_bits_ff  <= wanted_field_bits_in;
         wanted_field_count_ff <= wanted_field_count_in;
         phase_ff              <= phase_in;
         bytes_left_ff         <= bytes_left_in;
         byte_index_ff         <= byte_index_in;
         item_kind_ff          <= item_kind_in;
         item_label_ff         <= item_label_in;
         skip_count_ff         <= skip_count_in;
         value_accum_ff        <= value_accum_in;
         cur_report_id_ff      <= cur_report_id_in;
         cur_report_id_hi_ff   <= cur_report_id_hi_in;
         cur_field_bits_ff     <= cur_field_bits_in;
         cur_field_bits_hi_ff  <= cur_field_bits_hi_in;
         cur_field_count_ff    <= cur_field_count_in;
         cur_field_count_hi_ff <= cur_field_count_hi_in;
         verdict_ff            <= verdict_in;
         out_valid_ff          <= out_valid_in;
         skid_valid_ff         <= skid_valid_in;
      end
   end

   // Result payload registers need no reset.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- hdl/hdrm_checker.sv -----
// Port-level checks for the HID descriptor report matcher.
// Depends on hdrm_pkg; bound to hid_descriptor_report_matcher_top below.
module hdrm_checker
   import hdrm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic rsp_truncated
);

   // A result word waits until the receiver takes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A match never reports a cut-off descriptor.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_truncated))
      else $error("found and truncated both set");

   // Reset empties the result registers.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // A result word that raises rsp_valid always follows an accepted byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result word without an accepted byte");

endmodule

bind hid_descriptor_report_matcher_top hdrm_checker u_hdrm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_found     (rsp_chan.payload.found),
   .rsp_truncated (rsp_chan.payload.truncated)
);
